FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/mas_pkg.sv
// ----------------------------------------------------------------------------
// mas_pkg
// Shared constants and types of the stepper pulse generator.
// ----------------------------------------------------------------------------
package mas_pkg;
   localparam int AXES_DEF       = 4;
   localparam int STEP_WIDTH_DEF = 16;
   localparam int OUT_W          = 4;
   localparam int TPC_W          = 20;
   localparam int GAIN_W         = 32;
   localparam int ANG_W          = 15;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_JOINT  = 2'd2,
      OP_ROTARY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_GAIN  = 2'd0,
      CSR_TPC   = 2'd1,
      CSR_BASE  = 2'd2,
      CSR_NONE  = 2'd3
   } csr_type;
endpackage

FILE: hw/rtl/mas_div.sv
// ----------------------------------------------------------------------------
// mas_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mas_div #(
   parameter int NW = 20,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den;
         cnt_in = CW'(NW); run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

FILE: hw/rtl/mas_lane.sv
// ----------------------------------------------------------------------------
// mas_lane
// One axis: tick counter, period and remaining steps.
// ----------------------------------------------------------------------------
module mas_lane #(
   parameter int STEP_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [STEP_WIDTH-1:0] reset_period,
   input  logic                  tick,
   input  logic                  load_rem,
   input  logic [STEP_WIDTH-1:0] rem_value,
   input  logic                  load_per,
   input  logic [STEP_WIDTH-1:0] per_value,
   output logic                  pulse,
   output logic                  busy,
   output logic                  busy_next
);
   logic [STEP_WIDTH-1:0] cnt_ff, cnt_in, per_ff, per_in, rem_ff, rem_in;
   logic [STEP_WIDTH-1:0] inc;

   always_comb begin
      cnt_in = cnt_ff; per_in = per_ff; rem_in = rem_ff; pulse = 1'b0;
      inc = cnt_ff + 1'b1;
      if (tick && rem_ff != '0) begin
         cnt_in = inc;
         if (inc >= per_ff) begin
            cnt_in = '0; pulse = 1'b1; rem_in = rem_ff - 1'b1;
         end
      end
      if (load_rem) rem_in = rem_value;
      if (load_per) per_in = per_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; per_ff <= reset_period; rem_ff <= '0;
      end else begin
         cnt_ff <= cnt_in; per_ff <= per_in; rem_ff <= rem_in;
      end
   end

   assign busy      = rem_ff != '0;
   // Steps left once this cycle's tick or load has taken effect.
   assign busy_next = rem_in != '0;
endmodule

FILE: hw/rtl/multi_axis_stepper_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// multi_axis_stepper_pulse_generator_unit
// Multi-axis step pulse generator with joint move planning.
// ----------------------------------------------------------------------------
// channel | direction | handshake     | content
// req     | in        | valid/stall   | op, axis, angle, targets, delta
// rsp     | out       | valid/stall   | pulses, directions, busy, done
// csr     | in        | valid/ready   | register index and data
// Ticks, samples and rotary moves go from idle to the output state, which then
// raises the result; the next item is taken only once that result has left.
// A joint move passes, per joint, through the gain multiply and saturation
// states (S_MUL, S_WAIT, S_SAT) and, for a joint with steps to go, through the
// shared 20-bit serial divider (S_DIV).
// Reset is synchronous; periods reset to 10. A stalled result holds the block.
module multi_axis_stepper_pulse_generator_unit #(
   parameter int AXES       = mas_pkg::AXES_DEF,
   parameter int STEP_WIDTH = mas_pkg::STEP_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [1:0]             req_axis,
   input  logic [13:0]            req_raw_angle,
   input  logic signed [14:0]     req_target_0,
   input  logic signed [14:0]     req_target_1,
   input  logic signed [14:0]     req_target_2,
   input  logic signed [15:0]     req_rotary_delta,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_step_pulses,
   output logic [3:0]             rsp_dir_levels,
   output logic [3:0]             rsp_busy_axes,
   output logic                   rsp_rotary_done,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);
   localparam int ROT    = AXES - 1;
   localparam int JOINTS = (AXES - 1) < 3 ? (AXES - 1) : 3;
   localparam int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int PW     = 17 + mas_pkg::GAIN_W;
   localparam int TW     = mas_pkg::TPC_W;
   localparam logic [STEP_WIDTH-1:0] SMAX = '1;

   typedef enum logic [2:0] {S_IDLE, S_MUL, S_SAT, S_DIV, S_WAIT, S_OUT} st_type;

   logic [31:0] gain_ff;
   logic [TW-1:0] tpc_ff;
   logic [15:0] base_ff;
   logic signed [mas_pkg::ANG_W-1:0] ang_ff [3];
   logic [AXES-1:0] dir_ff;
   logic rbusy_ff;
   st_type st_ff;
   logic [JW-1:0] j_ff;
   logic signed [14:0] tgt_ff [3];
   logic [16:0] mag_ff;
   logic [PW-1:0] prod_ff;
   logic out_v_ff, done_ff;
   logic [3:0] pul_ff;
   logic [AXES-1:0] pulse_w, busy_w, busy_nx, ld_rem, ld_per, tick;
   logic [STEP_WIDTH-1:0] rem_v [AXES];
   logic [STEP_WIDTH-1:0] per_v [AXES];
   logic div_start, div_done;
   logic [TW-1:0] quo;
   logic acc;
   logic signed [16:0] err;
   logic [PW-17:0] shifted;
   logic [STEP_WIDTH-1:0] sat_steps, pq;
   logic [15:0] rmag;
   logic signed [15:0] rd;
   logic [13:0] raw;
   logic signed [14:0] raw_s;

   assign req_stall = (st_ff != S_IDLE);
   assign acc = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rd = req_rotary_delta;
   assign rmag = rd[15] ? 16'(-rd) : 16'(rd);
   assign raw = req_raw_angle;
   // A reading above half a turn wraps to a negative angle.
   assign raw_s = (raw > 14'd8192) ? signed'({1'b1, raw}) : signed'({1'b0, raw});
   assign err = 17'(tgt_ff[j_ff]) - 17'(ang_ff[j_ff]);
   assign shifted = prod_ff[PW-1:16];
   assign sat_steps = (shifted > (PW-16)'(SMAX)) ? SMAX : STEP_WIDTH'(shifted);
   assign pq = (quo == '0) ? STEP_WIDTH'(1) :
               (quo > TW'(SMAX)) ? SMAX : STEP_WIDTH'(quo);
   assign div_start = (st_ff == S_SAT) && (sat_steps != '0);

   mas_div #(.NW(TW), .DW(STEP_WIDTH)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(tpc_ff),
      .den(sat_steps), .done(div_done), .quo(quo));

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         tick[a] = acc && (mas_pkg::op_type'(req_op) == mas_pkg::OP_TICK);
         ld_rem[a] = 1'b0; ld_per[a] = 1'b0;
         rem_v[a] = sat_steps; per_v[a] = pq;
      end
      if (st_ff == S_SAT) ld_rem[j_ff] = 1'b1;
      if (st_ff == S_DIV && div_done) ld_per[j_ff] = 1'b1;
      if (acc && mas_pkg::op_type'(req_op) == mas_pkg::OP_ROTARY) begin
         ld_rem[ROT] = 1'b1; rem_v[ROT] = STEP_WIDTH'(rmag);
         if (STEP_WIDTH < 16 && rmag > 16'(SMAX)) rem_v[ROT] = SMAX;
         ld_per[ROT] = 1'b1; per_v[ROT] = STEP_WIDTH'(base_ff);
      end
   end

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      mas_lane #(.STEP_WIDTH(STEP_WIDTH)) u_lane (
         .clock(clock), .reset(reset), .reset_period(STEP_WIDTH'(10)),
         .tick(tick[g]), .load_rem(ld_rem[g]), .rem_value(rem_v[g]),
         .load_per(ld_per[g]), .per_value(per_v[g]),
         .pulse(pulse_w[g]), .busy(busy_w[g]), .busy_next(busy_nx[g]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 32'd65536; tpc_ff <= 20'd1000; base_ff <= 16'd10;
         for (int k = 0; k < 3; k++) ang_ff[k] <= '0;
         dir_ff <= '1; rbusy_ff <= 1'b0; st_ff <= S_IDLE; out_v_ff <= 1'b0;
         done_ff <= 1'b0; pul_ff <= '0; j_ff <= '0;
      end else begin
         if (csr_valid) begin
            unique case (mas_pkg::csr_type'(csr_index))
               mas_pkg::CSR_GAIN: gain_ff <= csr_data;
               mas_pkg::CSR_TPC:  tpc_ff  <= csr_data[19:0];
               mas_pkg::CSR_BASE: base_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         unique case (st_ff)
            S_IDLE: if (acc) begin
               pul_ff <= '0; done_ff <= 1'b0; st_ff <= S_OUT;
               unique case (mas_pkg::op_type'(req_op))
                  mas_pkg::OP_TICK: begin
                     pul_ff <= 4'(pulse_w);
                     // A tick that leaves no rotary steps also ends the move.
                     if (rbusy_ff && !busy_nx[ROT]) begin
                        rbusy_ff <= 1'b0; done_ff <= 1'b1;
                     end
                  end
                  mas_pkg::OP_SAMPLE:
                     if (req_axis < 2'd3 && 32'(req_axis) < JOINTS)
                        ang_ff[req_axis] <= raw_s;
                  mas_pkg::OP_JOINT: begin
                     tgt_ff[0] <= req_target_0; tgt_ff[1] <= req_target_1;
                     tgt_ff[2] <= req_target_2; j_ff <= '0; st_ff <= S_MUL;
                  end
                  mas_pkg::OP_ROTARY: begin
                     dir_ff[ROT] <= rd[15]; rbusy_ff <= 1'b1;
                  end
                  default: ;
               endcase
            end
            S_MUL: begin
               mag_ff <= err[16] ? 17'(-err) : 17'(err);
               st_ff <= S_WAIT;
            end
            S_WAIT: begin
               prod_ff <= PW'(mag_ff) * PW'(gain_ff);
               st_ff <= S_SAT;
            end
            S_SAT: begin
               dir_ff[j_ff] <= !(sat_steps != '0 && err[16]);
               st_ff <= S_DIV;
               if (sat_steps == '0) begin
                  if (32'(j_ff) == JOINTS - 1) st_ff <= S_OUT;
                  else begin j_ff <= j_ff + 1'b1; st_ff <= S_MUL; end
               end
            end
            S_DIV: if (div_done) begin
               if (32'(j_ff) == JOINTS - 1) st_ff <= S_OUT;
               else begin j_ff <= j_ff + 1'b1; st_ff <= S_MUL; end
            end
            S_OUT: begin
               out_v_ff <= 1'b1;
               if (out_v_ff && !rsp_stall) begin
                  out_v_ff <= 1'b0; st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_step_pulses = pul_ff;
   assign rsp_dir_levels  = 4'(dir_ff);
   assign rsp_busy_axes   = 4'(busy_w);
   assign rsp_rotary_done = done_ff;
endmodule

FILE: hw/rtl/mas_checker.sv
// ----------------------------------------------------------------------------
// mas_checker
// Port-level checks of the step pulse generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mas_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_step_pulses,
   input logic [3:0] rsp_dir_levels,
   input logic [3:0] rsp_busy_axes,
   input logic       rsp_rotary_done
);
   logic        held;
   logic [12:0] rsp_word;

   assign held     = rsp_valid && rsp_stall;
   assign rsp_word = {rsp_step_pulses, rsp_dir_levels, rsp_busy_axes, rsp_rotary_done};

   // While a result waits, no new item may enter.
   `ASSERT_CLK(a_busy_stall, rsp_valid |-> req_stall, "item taken while a result waits")
   `ASSERT_CLK(a_hold, held |=> rsp_valid && $stable(rsp_word), "result changed under stall")
   // A finished rotary move leaves the rotary axis idle.
   `ASSERT_CLK(a_done_idle, rsp_valid && rsp_rotary_done |-> !rsp_busy_axes[3], "done while busy")
   `ASSERT_ALWAYS(a_reset, reset |=> !rsp_valid, "result valid after reset")
endmodule

bind multi_axis_stepper_pulse_generator_unit mas_checker u_mas_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_step_pulses(rsp_step_pulses),
   .rsp_dir_levels(rsp_dir_levels), .rsp_busy_axes(rsp_busy_axes),
   .rsp_rotary_done(rsp_rotary_done));

FILE: dv/tb_multi_axis_stepper_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_multi_axis_stepper_pulse_generator_unit
// Self-checking bench for the four-axis step pulse generator. A cycle-free
// predictor tracks counters, periods, remaining steps, joint angles and
// direction bits for every accepted item. Each result is checked in order
// under random source gaps and sink stalls, across several register settings.
// ----------------------------------------------------------------------------
module tb_multi_axis_stepper_pulse_generator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic [3:0] pulses;
      logic [3:0] dirs;
      logic [3:0] busy;
      logic       done;
   } step_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_op = '0;
   logic [1:0]        req_axis = '0;
   logic [13:0]       req_raw_angle = '0;
   logic signed [14:0] req_target_0 = '0;
   logic signed [14:0] req_target_1 = '0;
   logic signed [14:0] req_target_2 = '0;
   logic signed [15:0] req_rotary_delta = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [3:0]        rsp_step_pulses;
   logic [3:0]        rsp_dir_levels;
   logic [3:0]        rsp_busy_axes;
   logic              rsp_rotary_done;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [31:0]       csr_data = '0;

   multi_axis_stepper_pulse_generator_unit dut (.*);

   always #5 clock = ~clock;

   // Predicted block state.
   logic [15:0] tick_cnt [4];
   logic [15:0] period_r [4];
   logic [15:0] remain [4];
   int          joint_ang [3];
   logic [3:0]  dir_r;
   bit          rot_busy;
   logic [31:0] cfg_gain = 32'd65536;
   logic [19:0] cfg_tpc = 20'd1000;
   logic [15:0] cfg_base = 16'd10;

   step_result_type expected_q [$];
   int    errors = 0;
   int    items_sent = 0;
   int    results_seen = 0;
   int    pulses_seen = 0;
   int    done_seen = 0;
   int    cycles = 0;
   int    stall_left = 0;
   bit    idle_off = 0;

   function automatic step_result_type predict_step(mas_pkg::op_type op, logic [1:0] ax,
         logic [13:0] raw, logic signed [14:0] t0, logic signed [14:0] t1,
         logic signed [14:0] t2, logic signed [15:0] rd);
      step_result_type    r;
      logic signed [14:0] tg [3];
      int                 err;
      int                 raw_i;
      int                 d;
      longint unsigned    mag;
      longint unsigned    steps;
      longint unsigned    per;
      r = '0;
      tg[0] = t0;
      tg[1] = t1;
      tg[2] = t2;
      case (op)
         mas_pkg::OP_TICK: begin
            for (int i = 0; i < 4; i++) begin
               if (remain[i] != 0) begin
                  tick_cnt[i] = tick_cnt[i] + 16'd1;
                  if (tick_cnt[i] >= period_r[i]) begin
                     tick_cnt[i] = '0;
                     r.pulses[i] = 1'b1;
                     remain[i] = remain[i] - 16'd1;
                  end
               end
            end
            if (rot_busy && remain[3] == 0) begin
               rot_busy = 0;
               r.done = 1'b1;
            end
         end
         mas_pkg::OP_SAMPLE: begin
            if (ax < 3) begin
               raw_i = int'(raw);
               if (raw_i > 8192) raw_i -= 16384;
               joint_ang[ax] = raw_i;
            end
         end
         mas_pkg::OP_JOINT: begin
            for (int i = 0; i < 3; i++) begin
               err = int'(tg[i]) - joint_ang[i];
               mag = longint'((err < 0) ? -err : err);
               steps = (mag * cfg_gain) >> 16;
               if (steps > 65535) steps = 65535;
               remain[i] = steps[15:0];
               dir_r[i] = !(steps != 0 && err < 0);
               if (steps != 0) begin
                  per = cfg_tpc / steps;
                  if (per == 0) per = 1;
                  if (per > 65535) per = 65535;
                  period_r[i] = per[15:0];
               end
            end
         end
         default: begin
            d = int'(rd);
            dir_r[3] = (d < 0);
            remain[3] = 16'((d < 0) ? -d : d);
            period_r[3] = cfg_base;
            rot_busy = 1;
         end
      endcase
      r.dirs = dir_r;
      for (int i = 0; i < 4; i++) r.busy[i] = (remain[i] != 0);
      return r;
   endfunction

   function automatic int draw_wait();
      return idle_off ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic logic signed [14:0] rand_target();
      int v;
      v = $urandom_range(0, 16384);
      return 15'(v - 8192);
   endfunction

   task automatic send_item(mas_pkg::op_type op, logic [1:0] ax, logic [13:0] raw,
         logic signed [14:0] t0, logic signed [14:0] t1, logic signed [14:0] t2,
         logic signed [15:0] rd);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_axis <= ax;
      req_raw_angle <= raw;
      req_target_0 <= t0;
      req_target_1 <= t1;
      req_target_2 <= t2;
      req_rotary_delta <= rd;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(predict_step(op, ax, raw, t0, t1, t2, rd));
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(mas_pkg::OP_TICK, 2'($urandom), 14'($urandom), rand_target(),
                rand_target(), rand_target(), 16'($urandom));
   endtask

   // Waits for every expected result, then waits on with no request so the
   // block is surely idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(mas_pkg::csr_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         mas_pkg::CSR_GAIN: cfg_gain = value;
         mas_pkg::CSR_TPC:  cfg_tpc = value[19:0];
         mas_pkg::CSR_BASE: cfg_base = value[15:0];
         default: ;
      endcase
   endtask

   task automatic test_directed();
      send_item(mas_pkg::OP_SAMPLE, 2'd0, 14'd0, 0, 0, 0, 0);
      send_item(mas_pkg::OP_SAMPLE, 2'd1, 14'd8192, 0, 0, 0, 0);
      send_item(mas_pkg::OP_SAMPLE, 2'd2, 14'd8193, 0, 0, 0, 0);
      send_item(mas_pkg::OP_SAMPLE, 2'd3, 14'd16383, 0, 0, 0, 0);   // ignored axis
      send_item(mas_pkg::OP_SAMPLE, 2'd2, 14'd16383, 0, 0, 0, 0);
      send_item(mas_pkg::OP_JOINT, 2'd0, 14'd0, -15'sd8192, 15'sd8192, 15'sd8192, 0);
      repeat (3) send_tick();
      send_item(mas_pkg::OP_JOINT, 2'd0, 14'd0, 15'sd0, 15'sd8192, -15'sd1, 0);
      send_item(mas_pkg::OP_ROTARY, 2'd0, 14'd0, 0, 0, 0, 16'sh8000);
      send_item(mas_pkg::OP_ROTARY, 2'd0, 14'd0, 0, 0, 0, 16'sd32767);
      send_item(mas_pkg::OP_ROTARY, 2'd0, 14'd0, 0, 0, 0, 16'sd0);  // done on next tick
      send_tick();
      send_item(mas_pkg::OP_ROTARY, 2'd0, 14'd0, 0, 0, 0, -16'sd2);
      repeat (25 - 14) send_tick();
   endtask

   task automatic run_random(int n);
      int stop;
      int kind;
      int a;
      stop = items_sent + n;
      while (items_sent < stop) begin
         kind = $urandom_range(0, 99);
         a = $urandom_range(0, 2);
         if (kind < 50) begin
            repeat ($urandom_range(1, 12)) send_tick();
         end else if (kind < 62) begin
            send_item(mas_pkg::OP_SAMPLE, 2'(a), 14'($urandom), rand_target(),
                      rand_target(), rand_target(), 16'($urandom));
         end else if (kind < 72) begin
            if ($urandom_range(0, 1))
               send_item(mas_pkg::OP_JOINT, 2'($urandom), 14'($urandom), rand_target(),
                         rand_target(), rand_target(), 16'($urandom));
            else
               send_item(mas_pkg::OP_JOINT, 2'($urandom), 14'($urandom),
                         15'(joint_ang[0] + $urandom_range(0, 6) - 3),
                         15'(joint_ang[1] + $urandom_range(0, 6) - 3),
                         15'(joint_ang[2] + $urandom_range(0, 6) - 3), 16'($urandom));
         end else if (kind < 84) begin
            send_item(mas_pkg::OP_ROTARY, 2'($urandom), 14'($urandom), rand_target(),
                      rand_target(), rand_target(),
                      $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                : 16'($urandom_range(0, 40) - 20));
         end else begin
            // Arbitrary item over the full field ranges, out-of-range sample axis too.
            send_item(mas_pkg::op_type'($urandom_range(0, 3)), 2'($urandom),
                      14'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                      16'($urandom));
         end
      end
   endtask

   task automatic test_config_sweep();
      logic [31:0] gains [6] = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd262144,
                                 32'd8192, 32'd65536};
      logic [31:0] tpcs [6] = '{32'd1000, 32'd1, 32'd1048575, 32'd500, 32'd20000,
                                32'd1000};
      logic [31:0] bases [6] = '{32'd10, 32'd1, 32'd65535, 32'd1, 32'd3, 32'd2};
      for (int s = 0; s < 6; s++) begin
         wait_idle();
         write_reg(mas_pkg::CSR_GAIN, gains[s]);
         write_reg(mas_pkg::CSR_TPC, tpcs[s]);
         write_reg(mas_pkg::CSR_BASE, bases[s]);
         run_random(250);
      end
   endtask

   task automatic test_drain_pause();
      repeat (3) begin
         run_random(20);
         wait_idle();
      end
   endtask

   task automatic test_back_to_back();
      idle_off = 1;
      run_random(120);
      idle_off = 0;
   endtask

   // Result checker and sink stall generator.
   always @(posedge clock) begin
      step_result_type exp_r;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_step_pulses != 0) pulses_seen++;
            if (rsp_rotary_done) done_seen++;
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result pulses=%h dirs=%h busy=%h done=%b",
                        $time, rsp_step_pulses, rsp_dir_levels, rsp_busy_axes,
                        rsp_rotary_done);
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_step_pulses !== exp_r.pulses) begin
                  errors++;
                  $display("%0t: step_pulses expected %h actual %h", $time,
                           exp_r.pulses, rsp_step_pulses);
               end
               if (rsp_dir_levels !== exp_r.dirs) begin
                  errors++;
                  $display("%0t: dir_levels expected %h actual %h", $time,
                           exp_r.dirs, rsp_dir_levels);
               end
               if (rsp_busy_axes !== exp_r.busy) begin
                  errors++;
                  $display("%0t: busy_axes expected %h actual %h", $time,
                           exp_r.busy, rsp_busy_axes);
               end
               if (rsp_rotary_done !== exp_r.done) begin
                  errors++;
                  $display("%0t: rotary_done expected %b actual %b", $time,
                           exp_r.done, rsp_rotary_done);
               end
            end
            stall_left = draw_wait();
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 4; i++) begin
         tick_cnt[i] = '0;
         period_r[i] = 16'd10;
         remain[i] = '0;
      end
      for (int i = 0; i < 3; i++) joint_ang[i] = 0;
      dir_r = 4'hF;
      rot_busy = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_sweep();
      test_drain_pause();
      test_back_to_back();
      wait_idle();
      $display("Covered %0d items and %0d results under all register extremes,",
               items_sent, results_seen);
      $display("with %0d pulsing ticks and %0d finished rotary moves.",
               pulses_seen, done_seen);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
